[rtl/rgbe_pkg.sv]
package rgbe_pkg;

   localparam int MaxWidthDefault = 4096;
   localparam int ExpBias         = 128 + 8;

   typedef enum logic [2:0] {
      ST_TAKEN   = 3'd0,
      ST_WAITING = 3'd1,
      ST_DONE    = 3'd2,
      ST_PIXEL   = 3'd3,
      ST_NOTHING = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BYTE,
      S_RUN,
      S_READ,
      S_CONV,
      S_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_byte;
      logic run_step;
      logic drain_read;
      logic drain_conv;
      logic load_out;
      logic [2:0] out_status;
      logic restart;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic row_ready;
      logic image_done;
      logic run_active;
   } sts_type;

   // exact single bits of (2m+1)*2^(e-137), zero when e is 0
   function automatic logic [31:0] to_single(input logic [7:0] m, input logic [7:0] e);
      logic [8:0]  v;
      logic [3:0]  p;
      int          top;
      logic [31:0] r;
      v = {m, 1'b1};
      p = 4'd0;
      for (int i = 1; i < 9; i++) begin
         if (v[i]) p = 4'(i);
      end
      top = int'(p) + int'(e) - (ExpBias + 1);
      if (e == 8'd0) begin
         r = 32'd0;
      end else if (top >= -126) begin
         r = {1'b0, 8'(top + 127), 23'((32'(v) << (5'd23 - 5'(p))) & 32'h7FFFFF)};
      end else begin
         r = 32'(v) << (int'(e) - (ExpBias + 1) + 149);
      end
      return r;
   endfunction

endpackage

[rtl/rgbe_ctrl.sv]
module rgbe_ctrl import rgbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  sts_type    sts,
   input  logic       cfg_write,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_kind) begin
                  state_in = S_BYTE;
               end else if (sts.row_ready) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_BYTE: state_in = sts.run_active ? S_RUN : S_OUT;
         S_RUN:  state_in = sts.run_active ? S_RUN : S_OUT;
         S_READ: state_in = S_CONV;
         S_CONV: state_in = S_OUT;
         S_OUT:  state_in = rsp_stall ? S_OUT : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_OUT);
      cmd.restart = cfg_write;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_out = 1'b1;
               if (!req_kind) begin
                  if (sts.row_ready) begin
                     cmd.out_status = ST_WAITING;
                  end else if (sts.image_done) begin
                     cmd.out_status = ST_DONE;
                  end else begin
                     cmd.out_status = ST_TAKEN;
                     cmd.take_byte  = 1'b1;
                  end
               end else if (sts.row_ready) begin
                  cmd.out_status = ST_PIXEL;
                  cmd.load_out   = 1'b0;
               end else begin
                  cmd.out_status = ST_NOTHING;
               end
            end
         end
         S_BYTE:  cmd.run_step = sts.run_active;
         S_RUN:   cmd.run_step = sts.run_active;
         S_READ:  cmd.drain_read = 1'b1;
         S_CONV:  cmd.drain_conv = 1'b1;
         default: ;
      endcase
   end

endmodule

[rtl/rgbe_dp.sv]
module rgbe_dp import rgbe_pkg::*; #(
   parameter int MAX_WIDTH = MaxWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_red_bits,
   output logic [31:0] rsp_green_bits,
   output logic [31:0] rsp_blue_bits,
   output logic [11:0] rsp_pixel_column,
   output logic [15:0] rsp_pixel_row,
   output logic        rsp_row_end,
   output logic        rsp_image_end
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = AW + 1;

   logic [31:0] mem [MAX_WIDTH];

   logic [12:0] width_ff;
   logic [15:0] height_ff;
   logic [23:0] lead_ff;
   logic [2:0]  lead_cnt_ff;
   logic        coded_ff;
   logic [1:0]  chan_ff;
   logic [CW-1:0] col_ff;
   logic [1:0]  phase_ff;
   logic [7:0]  left_ff;
   logic        ready_ff;
   logic [CW-1:0] drain_ff;
   logic [15:0] row_ff;
   logic [7:0]  run_byte_ff;
   logic [CW-1:0] run_left_ff;
   logic [31:0] rd_ff;
   logic        last_ff;

   logic [CW-1:0] weff;
   logic [15:0]   heff;
   always_comb begin
      if (width_ff == 13'd0) begin
         weff = CW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         weff = CW'(MAX_WIDTH);
      end else begin
         weff = CW'(width_ff);
      end
      heff = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end

   assign sts.row_ready  = ready_ff;
   assign sts.image_done = (row_ff >= heff);
   assign sts.run_active = (run_left_ff != '0);

   // byte writes: one write port with byte mask, one lane or all four
   logic          we;
   logic [AW-1:0] wa;
   logic [31:0]   wd;
   logic [3:0]    wm;

   logic [7:0] b;
   assign b = req_data_byte;
   logic [CW-1:0] room;
   assign room = weff - col_ff;

   // next state of the byte decoder
   logic [23:0]   lead_in;
   logic [2:0]    lead_cnt_in;
   logic          coded_in;
   logic [1:0]    chan_in;
   logic [CW-1:0] col_in;
   logic [1:0]    phase_in;
   logic [7:0]    left_in;
   logic          ready_in;
   logic [CW-1:0] run_left_in;
   logic          finish;
   logic          endch;

   always_comb begin
      lead_in = lead_ff; lead_cnt_in = lead_cnt_ff; coded_in = coded_ff;
      chan_in = chan_ff; col_in = col_ff; phase_in = phase_ff; left_in = left_ff;
      ready_in = ready_ff; run_left_in = run_left_ff;
      we = 1'b0; wa = AW'(col_ff); wd = {4{b}}; wm = 4'b0;
      finish = 1'b0; endch = 1'b0;
      if (cmd.take_byte) begin
         if (lead_cnt_ff < 3'd3) begin
            lead_in = {lead_ff[15:0], b};
            lead_cnt_in = lead_cnt_ff + 3'd1;
         end else if (lead_cnt_ff == 3'd3) begin
            lead_cnt_in = 3'd4; chan_in = 2'd0; phase_in = 2'd0; left_in = 8'd0;
            if (lead_ff[23:16] == 8'd2 && lead_ff[15:8] == 8'd2
                && 32'({lead_ff[7:0], b}) == 32'(weff)) begin
               coded_in = 1'b1; col_in = '0;
            end else begin
               coded_in = 1'b0;
               we = 1'b1; wa = '0; wm = 4'hF;
               wd = {b, lead_ff[7:0], lead_ff[15:8], lead_ff[23:16]};
               col_in = CW'(1);
               if (weff == CW'(1)) finish = 1'b1;
            end
         end else if (coded_ff) begin
            if (phase_ff == 2'd0) begin
               left_in = b; phase_in = 2'd1;
            end else if (phase_ff == 2'd1 && left_ff > 8'd128) begin
               // start a run; the sweep writes one entry per cycle
               run_left_in = (CW'(left_ff - 8'd128) > room) ? room
                                                            : CW'(left_ff - 8'd128);
               left_in = 8'd0; phase_in = 2'd0;
            end else begin
               we = 1'b1; wm = 4'b1 << chan_ff;
               col_in = col_ff + CW'(1);
               if (phase_ff == 2'd1) begin
                  left_in = (left_ff == 8'd0) ? 8'd0 : left_ff - 8'd1;
                  if (col_in >= weff) endch = 1'b1;
                  else phase_in = (left_in != 8'd0) ? 2'd2 : 2'd0;
               end else begin
                  if (left_ff != 8'd0) left_in = left_ff - 8'd1;
                  if (col_in >= weff) endch = 1'b1;
                  else if (left_in == 8'd0) phase_in = 2'd0;
               end
            end
         end else begin
            we = 1'b1; wm = 4'b1 << chan_ff;
            if (chan_ff == 2'd3) begin
               chan_in = 2'd0; col_in = col_ff + CW'(1);
               if (col_in >= weff) finish = 1'b1;
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
      end
      if (cmd.run_step) begin
         we = 1'b1; wm = 4'b1 << chan_ff; wd = {4{run_byte_ff}};
         col_in = col_ff + CW'(1);
         run_left_in = run_left_ff - CW'(1);
         if (run_left_in == '0 && col_in >= weff) endch = 1'b1;
      end
      if (endch) begin
         col_in = '0; phase_in = 2'd0; left_in = 8'd0;
         if (chan_ff == 2'd3) finish = 1'b1;
         else chan_in = chan_ff + 2'd1;
      end
      if (finish) begin
         ready_in = 1'b1; lead_cnt_in = 3'd0; lead_in = '0; chan_in = 2'd0;
         col_in = '0; coded_in = 1'b0; phase_in = 2'd0; left_in = 8'd0;
      end
      // release the row once its last pixel is out
      if (cmd.drain_conv && last_ff) ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         for (int i = 0; i < 4; i++) begin
            if (wm[i]) mem[wa][8*i +: 8] <= wd[8*i +: 8];
         end
      end
      rd_ff <= mem[AW'(drain_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd1; height_ff <= 16'd1;
      end else if (csr_write) begin
         if (csr_index == CSR_WIDTH) width_ff <= csr_data[12:0];
         else height_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         lead_ff <= '0; lead_cnt_ff <= '0; coded_ff <= 1'b0; chan_ff <= '0;
         col_ff <= '0; phase_ff <= '0; left_ff <= '0; ready_ff <= 1'b0;
         drain_ff <= '0; row_ff <= '0; run_left_ff <= '0;
      end else begin
         lead_ff <= lead_in; lead_cnt_ff <= lead_cnt_in; coded_ff <= coded_in;
         chan_ff <= chan_in; col_ff <= col_in; phase_ff <= phase_in;
         left_ff <= left_in; ready_ff <= ready_in; run_left_ff <= run_left_in;
         if (cmd.drain_read) begin
            last_ff <= (drain_ff + CW'(1) >= weff);
         end
         if (cmd.drain_conv) begin
            drain_ff <= last_ff ? '0 : drain_ff + CW'(1);
            if (last_ff) row_ff <= row_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte) run_byte_ff <= b;
      if (cmd.load_out) begin
         rsp_status <= cmd.out_status;
         rsp_red_bits <= '0; rsp_green_bits <= '0; rsp_blue_bits <= '0;
         rsp_pixel_column <= '0; rsp_pixel_row <= '0;
         rsp_row_end <= 1'b0; rsp_image_end <= 1'b0;
      end
      if (cmd.drain_conv) begin
         rsp_status <= ST_PIXEL;
         rsp_red_bits   <= to_single(rd_ff[7:0], rd_ff[31:24]);
         rsp_green_bits <= to_single(rd_ff[15:8], rd_ff[31:24]);
         rsp_blue_bits  <= to_single(rd_ff[23:16], rd_ff[31:24]);
         rsp_pixel_column <= 12'(drain_ff);
         rsp_pixel_row <= row_ff;
         rsp_row_end <= last_ff;
         rsp_image_end <= last_ff && (32'(row_ff) + 32'd1 >= 32'(heff));
      end
   end

endmodule

[rtl/rgbe_scanline_rle_decoder.sv]
// channel | ports                         | direction
// req     | req_valid/req_stall, kind,byte| in
// rsp     | rsp_valid/rsp_stall, 8 fields | out
// csr     | csr_write, csr_index, csr_data| in
// A run byte writes its copies one at a time in S_BYTE/S_RUN (one RAM write port).
// A drain tick with a row ready steps through RAM read, convert and output.
// Synchronous active-high reset; row buffer contents are not cleared.
// Input stalls while an item is in work or its result is held under rsp_stall.
module rgbe_scanline_rle_decoder import rgbe_pkg::*; #(
   parameter int MAX_WIDTH = MaxWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_red_bits,
   output logic [31:0] rsp_green_bits,
   output logic [31:0] rsp_blue_bits,
   output logic [11:0] rsp_pixel_column,
   output logic [15:0] rsp_pixel_row,
   output logic        rsp_row_end,
   output logic        rsp_image_end,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequence each item through its steps
   rgbe_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind,
      .rsp_valid, .rsp_stall, .sts, .cfg_write(csr_write), .cmd
   );

   // decode state, row buffer and float conversion
   rgbe_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock, .reset, .req_data_byte, .csr_write, .csr_index, .csr_data,
      .cmd, .sts, .rsp_status, .rsp_red_bits, .rsp_green_bits, .rsp_blue_bits,
      .rsp_pixel_column, .rsp_pixel_row, .rsp_row_end, .rsp_image_end
   );

endmodule

[sim/tb_rgbe_scanline_rle_decoder.sv]
`timescale 1ns / 100ps

import rgbe_pkg::*;

// One expected or observed result of the decoder.
typedef struct {
   logic [2:0]  status;
   logic [31:0] red;
   logic [31:0] green;
   logic [31:0] blue;
   logic [11:0] column;
   logic [15:0] row;
   logic        row_end;
   logic        image_end;
} pixel_result_type;

// Scoreboard: keeps its own copy of the decoder state, predicts the result
// of every accepted item and checks results in order.
class rgbe_scoreboard;
   localparam int unsigned MaxW = 4096;

   bit [31:0]   row_mem [MaxW];
   int unsigned lead_bytes, lead_count, row_coded, chan, col_pos;
   int unsigned span_phase, span_left, row_ready, drain_pos, row_count;
   int unsigned width_reg, height_reg;
   pixel_result_type expected_results [$];
   int          errors;

   function new();
      errors     = 0;
      width_reg  = 1;
      height_reg = 1;
      restart();
   endfunction

   function void restart();
      lead_bytes = 0; lead_count = 0; row_coded = 0; chan = 0; col_pos = 0;
      span_phase = 0; span_left = 0; row_ready = 0; drain_pos = 0; row_count = 0;
   endfunction

   function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxW) return MaxW;
      return width_reg;
   endfunction

   function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function void write_reg(csr_index_type idx, logic [15:0] value);
      if (idx == CSR_WIDTH) begin
         width_reg = value & 16'h1FFF;
      end else begin
         height_reg = value;
      end
      restart();
   endfunction

   function void put_byte(int unsigned col, int unsigned ch, logic [7:0] v);
      int unsigned sh;
      sh = 8 * (ch & 3);
      col = col & 13'h1FFF;
      if (col >= MaxW) return;
      row_mem[col] = (row_mem[col] & ~(32'hFF << sh)) | (32'(v) << sh);
   endfunction

   function void finish_row();
      row_ready = 1; drain_pos = 0; lead_count = 0; lead_bytes = 0;
      chan = 0; col_pos = 0; row_coded = 0; span_phase = 0; span_left = 0;
   endfunction

   function void end_channel();
      col_pos = 0; span_phase = 0; span_left = 0;
      if (chan >= 3) finish_row();
      else chan++;
   endfunction

   // Exact single bits of (2m+1) * 2^(e-137); zero when e is 0.
   function logic [31:0] hdr_float(logic [7:0] m, logic [7:0] e);
      logic [8:0]  v;
      int          p, k, top;
      logic [31:0] wide;
      if (e == 0) return 32'd0;
      v = {m, 1'b1};
      p = 0;
      for (int i = 1; i < 9; i++) if (v[i]) p = i;
      k = int'(e) - 137;
      top = p + k;
      wide = 32'(v);
      if (top >= -126) return {1'b0, 8'(top + 127), 23'((wide << (23 - p)) & 32'h7FFFFF)};
      return wide << (k + 149);
   endfunction

   function void take_coded(logic [7:0] b, int unsigned w);
      int unsigned n;
      if (span_phase == 0) begin
         span_left  = b;
         span_phase = 1;
      end else if (span_phase == 1) begin
         if (span_left > 128) begin
            n = span_left - 128;
            if (n > w - col_pos) n = w - col_pos;
            for (int unsigned i = 0; i < n; i++) put_byte(col_pos + i, chan, b);
            col_pos += n;
            span_left = 0;
            span_phase = 0;
            if (col_pos >= w) end_channel();
         end else begin
            put_byte(col_pos, chan, b);
            col_pos++;
            span_left = (span_left == 0) ? 0 : span_left - 1;
            if (col_pos >= w) end_channel();
            else span_phase = (span_left > 0) ? 2 : 0;
         end
      end else begin
         put_byte(col_pos, chan, b);
         col_pos++;
         if (span_left > 0) span_left--;
         if (col_pos >= w) end_channel();
         else if (span_left == 0) span_phase = 0;
      end
   endfunction

   function void take_byte(logic [7:0] b);
      int unsigned w;
      logic [7:0]  b0, b1, b2;
      w = eff_width();
      if (lead_count < 3) begin
         lead_bytes = ((lead_bytes << 8) | b) & 24'hFFFFFF;
         lead_count++;
      end else if (lead_count == 3) begin
         b0 = lead_bytes[23:16];
         b1 = lead_bytes[15:8];
         b2 = lead_bytes[7:0];
         lead_count = 4; chan = 0; span_phase = 0; span_left = 0;
         if (b0 == 2 && b1 == 2 && {b2, b} == w) begin
            row_coded = 1;
            col_pos = 0;
         end else begin
            row_coded = 0;
            row_mem[0] = {b, b2, b1, b0};
            col_pos = 1;
            if (w == 1) finish_row();
         end
      end else if (row_coded) begin
         take_coded(b, w);
      end else begin
         put_byte(col_pos, chan, b);
         if (chan >= 3) begin
            chan = 0;
            col_pos++;
            if (col_pos >= w) finish_row();
         end else begin
            chan++;
         end
      end
   endfunction

   // Predict the result of one accepted item.
   function void note_item(logic kind, logic [7:0] b);
      pixel_result_type r;
      bit [31:0]     px;
      bit            last;
      r = '{status: ST_TAKEN, red: 0, green: 0, blue: 0, column: 0, row: 0,
            row_end: 0, image_end: 0};
      if (kind == 1'b0) begin
         if (row_ready) r.status = ST_WAITING;
         else if (row_count >= eff_height()) r.status = ST_DONE;
         else take_byte(b);
      end else if (!row_ready) begin
         r.status = ST_NOTHING;
      end else begin
         px = row_mem[drain_pos & (MaxW - 1)];
         last = (drain_pos + 1 >= eff_width());
         r.status    = ST_PIXEL;
         r.red       = hdr_float(px[7:0], px[31:24]);
         r.green     = hdr_float(px[15:8], px[31:24]);
         r.blue      = hdr_float(px[23:16], px[31:24]);
         r.column    = drain_pos[11:0];
         r.row       = row_count[15:0];
         r.row_end   = last;
         r.image_end = last && (row_count + 1 >= eff_height());
         drain_pos++;
         if (last) begin
            row_ready = 0;
            drain_pos = 0;
            row_count = (row_count + 1) & 16'hFFFF;
         end
      end
      expected_results.push_back(r);
   endfunction

   task report(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task check_result(pixel_result_type got);
      pixel_result_type want;
      if (expected_results.size() == 0) begin
         report($sformatf("unexpected result, status %0d", got.status));
         return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
         report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.red !== want.red)
         report($sformatf("red %h, want %h", got.red, want.red));
      if (got.green !== want.green)
         report($sformatf("green %h, want %h", got.green, want.green));
      if (got.blue !== want.blue)
         report($sformatf("blue %h, want %h", got.blue, want.blue));
      if (got.column !== want.column)
         report($sformatf("column %0d, want %0d", got.column, want.column));
      if (got.row !== want.row)
         report($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.row_end !== want.row_end)
         report($sformatf("row_end %b, want %b", got.row_end, want.row_end));
      if (got.image_end !== want.image_end)
         report($sformatf("image_end %b, want %b", got.image_end, want.image_end));
   endtask
endclass

module tb_rgbe_scanline_rle_decoder;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_red_bits, rsp_green_bits, rsp_blue_bits;
   logic [11:0] rsp_pixel_column;
   logic [15:0] rsp_pixel_row;
   logic        rsp_row_end, rsp_image_end;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = 16'd0;

   rgbe_scoreboard sb;
   int          send_idle_pct = 0;   // chance per cycle that the sender holds back
   int          stall_pct = 0;       // chance per cycle that the receiver stalls
   int          hold_left = 0;       // cycles left in a long receiver hold-off
   int          sent_items = 0;

   always #5 clock = ~clock;

   rgbe_scanline_rle_decoder dut (.*);

   // Receiver: stall at random, or for a long stretch when asked.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Check every result taken at this edge.
   always @(posedge clock) begin
      pixel_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status    = rsp_status;
         got.red       = rsp_red_bits;
         got.green     = rsp_green_bits;
         got.blue      = rsp_blue_bits;
         got.column    = rsp_pixel_column;
         got.row       = rsp_pixel_row;
         got.row_end   = rsp_row_end;
         got.image_end = rsp_image_end;
         sb.check_result(got);
      end
   end

   // Offer one item and hold it until the block takes it.
   task send_item(logic kind, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_item(kind, b);
      sent_items++;
   endtask

   task send_byte(logic [7:0] b);
      send_item(1'b0, b);
   endtask

   task send_tick();
      send_item(1'b1, 8'($urandom));
   endtask

   // Drop valid and wait until every expected result is in.
   task drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Write a register while the block sits idle.
   task write_reg(csr_index_type idx, logic [15:0] value);
      drain_results();
      repeat (10) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_write <= 1'b0;
   endtask

   // Spans for one channel plane of a coded row; runs, literals, clipped ones.
   task send_plane(int unsigned w, int big_runs);
      int unsigned filled, cnt, n;
      filled = 0;
      while (filled < w) begin
         if (big_runs != 0 || $urandom_range(1)) begin
            cnt = big_runs ? 255 : $urandom_range(255, 129);
            send_byte(8'(cnt));
            send_byte(8'($urandom));
            n = cnt - 128;
         end else begin
            cnt = $urandom_range(9) == 0 ? ($urandom_range(1) ? 0 : 128) :
                  $urandom_range(6, 1);
            n = (cnt == 0) ? 1 : cnt;
            if (n > w - filled) n = w - filled;
            send_byte(8'(cnt));
            repeat (n) send_byte(8'($urandom));
         end
         filled += n;
      end
   endtask

   task send_coded_row(int unsigned w, int big_runs);
      send_byte(8'd2);
      send_byte(8'd2);
      send_byte(8'(w >> 8));
      send_byte(8'(w));
      repeat (4) send_plane(w, big_runs);
   endtask

   task send_flat_row(int unsigned w);
      repeat (4 * w) send_byte(8'($urandom));
   endtask

   // One whole image: rows of random form, each drained, plus some noise.
   task send_image(int unsigned w, int unsigned h);
      for (int unsigned r = 0; r < h; r++) begin
         if ($urandom_range(7) == 0) send_tick();
         if ($urandom_range(1)) send_coded_row(w, 0);
         else send_flat_row(w);
         if ($urandom_range(3) == 0) send_byte(8'($urandom));
         repeat (w) send_tick();
         if ($urandom_range(4) == 0) send_tick();
      end
      if ($urandom_range(2) == 0) send_byte(8'($urandom));
   endtask

   task random_phase(int idle, int stall, int quota);
      int unsigned w, h;
      int          start;
      send_idle_pct = idle;
      stall_pct     = stall;
      start = sent_items;
      while (sent_items - start < quota) begin
         w = ($urandom_range(5) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
         h = $urandom_range(3, 1);
         if ($urandom_range(9) == 0) w = 0;
         write_reg(CSR_WIDTH, 16'(w));
         write_reg(CSR_HEIGHT, ($urandom_range(9) == 0) ? 16'd0 : 16'(h));
         if (sent_items - start > quota / 2 && hold_left == 0 && $urandom_range(3) == 0)
            hold_left = 300;
         send_image(w, h);
      end
      drain_results();
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: width 3, two rows; first row coded with every span kind.
      write_reg(CSR_WIDTH, 16'd3);
      write_reg(CSR_HEIGHT, 16'd2);
      send_tick();                          // nothing to give
      send_byte(8'd2); send_byte(8'd2); send_byte(8'd0); send_byte(8'd3);
      send_byte(8'd131); send_byte(8'hFF);  // run of three
      send_byte(8'd0); send_byte(8'hAA);    // count zero acts as one
      send_byte(8'd128); send_byte(8'h55); send_byte(8'h01);  // literal 128, clipped
      send_byte(8'd255); send_byte(8'h80);  // longest run, clipped
      send_byte(8'd2); send_byte(8'h00); send_byte(8'hFF);
      send_byte(8'd129); send_byte(8'h7F);
      send_byte(8'h12);                     // refused while a row waits
      repeat (3) send_tick();
      send_tick();
      // Second row: 2, 2 with the wrong width is a flat row.
      send_byte(8'd2); send_byte(8'd2); send_byte(8'd0); send_byte(8'd4);
      repeat (8) send_byte(8'($urandom));
      repeat (3) send_tick();
      send_byte(8'hFF);                     // refused after the last row

      // Extremes of the registers: widest width saturates, tallest height.
      write_reg(CSR_HEIGHT, 16'hFFFF);
      write_reg(CSR_WIDTH, 16'h1FFF);
      send_byte(8'd2); send_byte(8'd2); send_byte(8'h10); send_byte(8'h00);
      send_byte(8'd255); send_byte(8'h3C);  // longest run into a saturated row
      send_tick();                          // row not complete yet
      write_reg(CSR_WIDTH, 16'd4096);
      send_byte(8'd2); send_byte(8'd2); send_byte(8'h10); send_byte(8'h00);
      send_tick();

      // Long receiver hold-off while the sender keeps offering.
      write_reg(CSR_WIDTH, 16'd6);
      write_reg(CSR_HEIGHT, 16'd3);
      hold_left = 400;
      send_image(6, 3);

      // Random phases; the sender pauses for all results between them.
      random_phase(0, 0, 70);
      random_phase(57, 0, 70);
      random_phase(0, 57, 70);
      random_phase(12, 12, 70);

      drain_results();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.expected_results.size() == 0) begin
         $display("tb_rgbe_scanline_rle_decoder: done, clean");
      end else begin
         $display("tb_rgbe_scanline_rle_decoder: done, errors");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #20ms;
      $display("tb_rgbe_scanline_rle_decoder: done, errors");
      $finish;
   end
endmodule
